// ===== src/clm_pkg.sv =====
// Shared types and constants for the cursor list manager.
`timescale 1ns / 1ps

package clm_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_USED  = 2 * LEN_W + 3 * VAL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED + 7) / 8) * 8;
  localparam int unsigned PAD_W     = OUT_DATA_W - OUT_USED;

  // Read tree fan-in per registered level.
  localparam int unsigned TREE_BITS = 4;
  localparam int unsigned TREE_FAN  = 1 << TREE_BITS;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR      = 4'd0,
    CMD_PREPEND    = 4'd1,
    CMD_APPEND     = 4'd2,
    CMD_INS_BEFORE = 4'd3,
    CMD_INS_AFTER  = 4'd4,
    CMD_DEL_FRONT  = 4'd5,
    CMD_DEL_BACK   = 4'd6,
    CMD_DEL_CURSOR = 4'd7,
    CMD_MV_FRONT   = 4'd8,
    CMD_MV_BACK    = 4'd9,
    CMD_PREV       = 4'd10,
    CMD_NEXT       = 4'd11,
    CMD_SET        = 4'd12,
    CMD_PEEK       = 4'd13
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_UNDEF = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  // Edit broadcast to the cell row.
  typedef enum logic [1:0] {
    EDIT_HOLD   = 2'd0,
    EDIT_INSERT = 2'd1,
    EDIT_DELETE = 2'd2,
    EDIT_WRITE  = 2'd3
  } edit_kind_t;

endpackage

// ===== src/clm_cell.sv =====
// One list cell: holds the element at a fixed position and shifts with its neighbors.
`timescale 1ns / 1ps

module clm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned EW  = 32,
  parameter int unsigned AW  = 8
) (
  input  logic                   clk,
  input  clm_pkg::edit_kind_t    kind,
  input  logic [AW-1:0]          pos,
  input  logic [EW-1:0]          wval,
  input  logic [EW-1:0]          left_data,
  input  logic [EW-1:0]          right_data,
  output logic [EW-1:0]          data
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  always_ff @(posedge clk) begin
    case (kind)
      clm_pkg::EDIT_INSERT: begin
        // open a gap at pos: cells past it take the left neighbor
        if (MY_IDX > pos) begin
          data <= left_data;
        end else if (MY_IDX == pos) begin
          data <= wval;
        end
      end
      clm_pkg::EDIT_DELETE: begin
        // close the gap at pos
        if (MY_IDX >= pos) begin
          data <= right_data;
        end
      end
      clm_pkg::EDIT_WRITE: begin
        if (MY_IDX == pos) begin
          data <= wval;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ===== src/clm_read_tree.sv =====
// Registered AND-OR tree that reads one cell of the row at a selected position.
`timescale 1ns / 1ps

module clm_read_tree #(
  parameter int unsigned NLEAF = 256,
  parameter int unsigned EW    = 32,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic [EW-1:0] leaf [NLEAF],
  input  logic          en,
  input  logic [AW-1:0] addr,
  output logic [EW-1:0] root
);

  localparam int unsigned LEVELS = (AW + clm_pkg::TREE_BITS - 1) / clm_pkg::TREE_BITS;

  function automatic int unsigned lvl_size(int unsigned l);
    return 1 << (clm_pkg::TREE_BITS * (LEVELS - 1 - l));
  endfunction

  function automatic int unsigned lvl_off(int unsigned l);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < l; k++) begin
      acc = acc + lvl_size(k);
    end
    return acc;
  endfunction

  localparam int unsigned TOTAL = lvl_off(LEVELS);

  logic [EW-1:0] node [TOTAL];

  genvar l, j;
  generate
    for (l = 0; l < LEVELS; l++) begin : g_lvl
      for (j = 0; j < lvl_size(l); j++) begin : g_node
        logic [EW-1:0] sum_c;
        if (l == 0) begin : g_leaf
          // select the matching leaf of this group
          always_comb begin
            sum_c = '0;
            for (int unsigned k = 0; k < clm_pkg::TREE_FAN; k++) begin
              if ((j * clm_pkg::TREE_FAN + k) < NLEAF) begin
                if (en && (addr == AW'(j * clm_pkg::TREE_FAN + k))) begin
                  sum_c = sum_c | leaf[j * clm_pkg::TREE_FAN + k];
                end
              end
            end
          end
        end else begin : g_inner
          always_comb begin
            sum_c = '0;
            for (int unsigned k = 0; k < clm_pkg::TREE_FAN; k++) begin
              sum_c = sum_c | node[lvl_off(l - 1) + j * clm_pkg::TREE_FAN + k];
            end
          end
        end
        always_ff @(posedge clk) begin
          node[lvl_off(l) + j] <= sum_c;
        end
      end
    end
  endgenerate

  assign root = node[TOTAL-1];

endmodule

// ===== src/cursor_list_manager_unit.sv =====
// Top level: command decode, cursor and length state, cell row and result register.
// The result word is loaded once the cell read tree has settled and there is room downstream;
//   LEVELS = ceil(log2(CAPACITY)/4) registered levels of the cell read tree (2 at 256).
// The input is closed while a command passes the read tree; when idle a command is taken
//   at once, else a new command is taken in the same cycle its predecessor's result loads.
// Reset: list empty, cursor undefined, no result pending; the cell row holds no
//   reset and needs no clearing pass.
`timescale 1ns / 1ps

module cursor_list_manager_unit #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [clm_pkg::IN_DATA_W-1:0]     s_tdata,   // value[31:0]
  input  logic [clm_pkg::CMD_W-1:0]         s_tuser,   // cmd[3:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // list_length[8:0], cursor_index[17:9], front_value[49:18], back_value[81:50],
  // cursor_value[113:82], zero pad
  output logic [clm_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [clm_pkg::STATUS_W-1:0]      m_tuser    // status[1:0]
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = ELEM_WIDTH;
  localparam int unsigned LEVELS = (IW + clm_pkg::TREE_BITS - 1) / clm_pkg::TREE_BITS;
  localparam int unsigned WCNT_W = $clog2(LEVELS + 1);
  localparam int unsigned VW = clm_pkg::VAL_W;
  localparam int unsigned LW = clm_pkg::LEN_W;

  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
  localparam logic [IW-1:0] POS_ONE  = IW'(1);
  localparam logic [WCNT_W-1:0] WAIT_LAST = WCNT_W'(LEVELS - 1);

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    WAIT = 3'b010,
    FILL = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [WCNT_W-1:0]    wait_cnt;

  logic [CW-1:0]        count, count_next;
  logic                 cur_ok, cur_ok_next;
  logic [IW-1:0]        cur_pos, cur_pos_next;
  clm_pkg::status_t     status_hold, status_next;

  clm_pkg::edit_kind_t  kind_c, edit_kind;
  logic [IW-1:0]        edit_pos;

  logic                 accept, out_free, capture;
  logic                 empty, full, one_left;
  logic [CW-1:0]        cnt_m1, pos_wide;
  clm_pkg::cmd_t        cmd;

  logic [EW+VW-1:0]     val_ext;
  logic [EW-1:0]        wval;

  logic [EW-1:0]        cell_data [CAPACITY];
  logic [EW-1:0]        left_in   [CAPACITY];
  logic [EW-1:0]        right_in  [CAPACITY];

  logic [EW-1:0]        back_raw, curv_raw, front_raw;
  logic [EW+VW-1:0]     front_sx, back_sx, curv_sx;
  logic [CW+LW-1:0]     len_ext;
  logic [IW+LW-1:0]     idx_ext;

  logic [LW-1:0]        out_len, out_idx;
  logic [VW-1:0]        out_front, out_back, out_cur;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) || ((state == FILL) && out_free);
  assign accept   = s_tvalid && s_tready;
  assign capture  = (state == FILL) && out_free;

  assign cmd      = clm_pkg::cmd_t'(s_tuser);
  assign empty    = (count == '0);
  assign full     = (count == CNT_FULL);
  assign one_left = (count == CNT_ONE);
  assign cnt_m1   = count - CNT_ONE;
  assign pos_wide = CW'(cur_pos);

  assign val_ext = {{EW{s_tdata[VW-1]}}, s_tdata[VW-1:0]};
  assign wval    = val_ext[EW-1:0];

  // Command decode against the state before the command.
  always_comb begin
    status_next  = clm_pkg::STAT_OK;
    count_next   = count;
    cur_ok_next  = cur_ok;
    cur_pos_next = cur_pos;
    kind_c       = clm_pkg::EDIT_HOLD;
    edit_pos     = cur_pos;
    case (cmd)
      clm_pkg::CMD_CLEAR: begin
        count_next  = '0;
        cur_ok_next = 1'b0;
      end
      clm_pkg::CMD_PREPEND: begin
        if (full) begin
          status_next = clm_pkg::STAT_FULL;
        end else begin
          kind_c     = clm_pkg::EDIT_INSERT;
          edit_pos   = '0;
          count_next = count + CNT_ONE;
          if (cur_ok) begin
            cur_pos_next = cur_pos + POS_ONE;
          end
        end
      end
      clm_pkg::CMD_APPEND: begin
        if (full) begin
          status_next = clm_pkg::STAT_FULL;
        end else begin
          kind_c     = clm_pkg::EDIT_WRITE;
          edit_pos   = count[IW-1:0];
          count_next = count + CNT_ONE;
        end
      end
      clm_pkg::CMD_INS_BEFORE, clm_pkg::CMD_INS_AFTER: begin
        if (empty) begin
          status_next = clm_pkg::STAT_EMPTY;
        end else if (!cur_ok) begin
          status_next = clm_pkg::STAT_UNDEF;
        end else if (full) begin
          status_next = clm_pkg::STAT_FULL;
        end else begin
          kind_c     = clm_pkg::EDIT_INSERT;
          count_next = count + CNT_ONE;
          if (cmd == clm_pkg::CMD_INS_BEFORE) begin
            // cursor element moves up by one
            edit_pos     = cur_pos;
            cur_pos_next = cur_pos + POS_ONE;
          end else begin
            edit_pos = cur_pos + POS_ONE;
          end
        end
      end
      clm_pkg::CMD_DEL_FRONT: begin
        if (empty) begin
          status_next = clm_pkg::STAT_EMPTY;
        end else if (one_left) begin
          count_next  = '0;
          cur_ok_next = 1'b0;
        end else begin
          kind_c     = clm_pkg::EDIT_DELETE;
          edit_pos   = '0;
          count_next = cnt_m1;
          if (cur_ok) begin
            if (cur_pos == '0) begin
              cur_ok_next = 1'b0;
            end else begin
              cur_pos_next = cur_pos - POS_ONE;
            end
          end
        end
      end
      clm_pkg::CMD_DEL_BACK: begin
        if (empty) begin
          status_next = clm_pkg::STAT_EMPTY;
        end else if (one_left) begin
          count_next  = '0;
          cur_ok_next = 1'b0;
        end else begin
          count_next = cnt_m1;
          if (cur_ok && (pos_wide == cnt_m1)) begin
            cur_ok_next = 1'b0;
          end
        end
      end
      clm_pkg::CMD_DEL_CURSOR: begin
        if (empty) begin
          status_next = clm_pkg::STAT_EMPTY;
        end else if (!cur_ok) begin
          status_next = clm_pkg::STAT_UNDEF;
        end else begin
          kind_c      = clm_pkg::EDIT_DELETE;
          edit_pos    = cur_pos;
          count_next  = cnt_m1;
          cur_ok_next = 1'b0;
        end
      end
      clm_pkg::CMD_MV_FRONT: begin
        if (!empty) begin
          cur_ok_next  = 1'b1;
          cur_pos_next = '0;
        end
      end
      clm_pkg::CMD_MV_BACK: begin
        if (!empty) begin
          cur_ok_next  = 1'b1;
          cur_pos_next = cnt_m1[IW-1:0];
        end
      end
      clm_pkg::CMD_PREV: begin
        if (cur_ok) begin
          if (cur_pos == '0) begin
            cur_ok_next = 1'b0;
          end else begin
            cur_pos_next = cur_pos - POS_ONE;
          end
        end
      end
      clm_pkg::CMD_NEXT: begin
        if (cur_ok) begin
          if ((pos_wide + CNT_ONE) >= count) begin
            cur_ok_next = 1'b0;
          end else begin
            cur_pos_next = cur_pos + POS_ONE;
          end
        end
      end
      clm_pkg::CMD_SET: begin
        if (empty) begin
          status_next = clm_pkg::STAT_EMPTY;
        end else if (!cur_ok) begin
          status_next = clm_pkg::STAT_UNDEF;
        end else begin
          kind_c   = clm_pkg::EDIT_WRITE;
          edit_pos = cur_pos;
        end
      end
      default: begin
        status_next = clm_pkg::STAT_OK;
      end
    endcase
  end

  assign edit_kind = accept ? kind_c : clm_pkg::EDIT_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_ok  <= 1'b0;
      cur_pos <= '0;
    end else if (accept) begin
      count   <= count_next;
      cur_ok  <= cur_ok_next;
      cur_pos <= cur_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_hold <= status_next;
    end
  end

  // Sequencer: wait out the read tree, then load the result word.
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          state_next = WAIT;
        end
      end
      WAIT: begin
        if (wait_cnt == WAIT_LAST) begin
          state_next = FILL;
        end
      end
      FILL: begin
        if (capture) begin
          state_next = accept ? WAIT : IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      wait_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        wait_cnt <= '0;
      end else if (state == WAIT) begin
        wait_cnt <= wait_cnt + WCNT_W'(1);
      end
    end
  end

  // Cell row.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign left_in[i] = '0;
      end else begin : g_left
        assign left_in[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_in[i] = '0;
      end else begin : g_right
        assign right_in[i] = cell_data[i+1];
      end
      clm_cell #(
        .IDX (i),
        .EW  (EW),
        .AW  (IW)
      ) u_cell (
        .clk        (clk),
        .kind       (edit_kind),
        .pos        (edit_pos),
        .wval       (wval),
        .left_data  (left_in[i]),
        .right_data (right_in[i]),
        .data       (cell_data[i])
      );
    end
  endgenerate

  clm_read_tree #(
    .NLEAF (CAPACITY),
    .EW    (EW),
    .AW    (IW)
  ) u_back_tree (
    .clk  (clk),
    .leaf (cell_data),
    .en   (!empty),
    .addr (cnt_m1[IW-1:0]),
    .root (back_raw)
  );

  clm_read_tree #(
    .NLEAF (CAPACITY),
    .EW    (EW),
    .AW    (IW)
  ) u_cur_tree (
    .clk  (clk),
    .leaf (cell_data),
    .en   (cur_ok),
    .addr (cur_pos),
    .root (curv_raw)
  );

  assign front_raw = empty ? '0 : cell_data[0];
  assign front_sx  = {{VW{front_raw[EW-1]}}, front_raw};
  assign back_sx   = {{VW{back_raw[EW-1]}}, back_raw};
  assign curv_sx   = {{VW{curv_raw[EW-1]}}, curv_raw};
  assign len_ext   = {{LW{1'b0}}, count};
  assign idx_ext   = {{LW{1'b0}}, cur_pos};

  // Result register; count and cursor still hold this command's outcome here.
  always_ff @(posedge clk) begin
    if (capture) begin
      m_tuser   <= status_hold;
      out_len   <= len_ext[LW-1:0];
      out_idx   <= cur_ok ? idx_ext[LW-1:0] : '1;
      out_front <= front_sx[VW-1:0];
      out_back  <= back_sx[VW-1:0];
      out_cur   <= curv_sx[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {{clm_pkg::PAD_W{1'b0}}, out_cur, out_back, out_front, out_idx, out_len};

  // A defined cursor always lies inside the list.
  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    cur_ok |-> (pos_wide < count))
    else $error("cursor position beyond list length");

  // Taking a word closes the input until the read tree has settled.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input open right after a command was taken");

  // A settled result with room downstream is loaded.
  a_capture_loads: assert property (@(posedge clk) disable iff (rst)
    capture |=> m_tvalid)
    else $error("result word not loaded");

  // A full status leaves the length untouched.
  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next == clm_pkg::STAT_FULL)) |=> (count == $past(count)))
    else $error("length changed on a full store");

endmodule
